### rtl/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types and register map constants of the platform interrupt controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pic_pkg;

    // bus and event commands
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RAISE = 2'd2;

    // register map
    localparam logic [25:0] OFF_PENDING    = 26'h001000;
    localparam logic [25:0] OFF_ENABLE     = 26'h002000;
    localparam int          ENABLE_STRIDE  = 'h80;
    localparam logic [25:0] OFF_THRESHOLD  = 26'h200000;
    localparam int          CONTEXT_STRIDE = 'h1000;
    localparam logic [11:0] OFF_CLAIM      = 12'h004;
    localparam int          ENABLE_SHIFT   = $clog2(ENABLE_STRIDE);
    localparam int          CONTEXT_SHIFT  = $clog2(CONTEXT_STRIDE);
    localparam int          SUPERVISOR_CTX = 1;

    typedef struct packed {
        logic [1:0]  command;
        logic [25:0] address;
        logic [31:0] write_data;
        logic [4:0]  source;
    } t_pic_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic        supervisor_irq;
    } t_pic_out;

endpackage

`default_nettype wire

### rtl/platform_interrupt_controller_unit.sv
// ----------------------------------------------------------------------------
// platform_interrupt_controller_unit
// Interrupt controller with per-source priorities and per-context enables.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one beat per bus read, bus write or source
//   raise (i_in_valid / o_in_stall). The output channel returns exactly one
//   beat per input beat with the read data and the supervisor line level
//   (o_out_valid / i_out_stall).
//   Source priorities live in a single-port synchronous memory. After each
//   beat the block walks the priority memory one source per cycle to find
//   the best claimable source, so the walk over the priority memory read
//   port sets the rate of beats. A priority read adds a read state before
//   the walk, and a claim read walks once for the claiming context and
//   once for the supervisor.
//   The input side takes one beat at a time and holds o_in_stall high while
//   it works. A finished result sits in an output register; the next beat
//   is accepted while it waits, and the block only holds its next result
//   until the receiver drops i_out_stall.
//   Reset clears all pending, claimed, enable, threshold and priority valid
//   bits, so all priorities read as zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module platform_interrupt_controller_unit
    import pic_pkg::*;
#(
    parameter int NUM_SOURCES  = 32,
    parameter int NUM_CONTEXTS = 2
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_pic_in  i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_pic_out      o_out_data
);

    localparam int SW = $clog2(NUM_SOURCES);
    localparam int CW = $clog2(NUM_CONTEXTS);
    localparam logic [SW-1:0] LAST_SRC = SW'(NUM_SOURCES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_PRD  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [2:0] K_NONE   = 3'd0;
    localparam logic [2:0] K_PRIO   = 3'd1;
    localparam logic [2:0] K_PEND   = 3'd2;
    localparam logic [2:0] K_ENAB   = 3'd3;
    localparam logic [2:0] K_THRESH = 3'd4;
    localparam logic [2:0] K_CLAIM  = 3'd5;

    logic [2:0]             r_state;
    logic [1:0]             r_cmd;
    logic [2:0]             r_kind;
    logic [SW-1:0]          r_sel;
    logic [CW-1:0]          r_ctx;
    logic [31:0]            r_wdata;
    logic [4:0]             r_src;
    logic [31:0]            r_rd;
    logic                   r_irq;
    logic                   r_claim_scan;

    logic [NUM_SOURCES-1:0] r_pending;
    logic [NUM_SOURCES-1:0] r_claimed;
    logic [31:0]            r_enable [NUM_CONTEXTS];
    logic [31:0]            r_thresh [NUM_CONTEXTS];

    logic [31:0]            mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] r_prio_vld;
    logic [31:0]            r_mem_q;
    logic                   r_q_vld;

    logic [SW-1:0]          r_sidx;
    logic                   r_issue;
    logic [SW-1:0]          r_cidx;
    logic                   r_cvld;
    logic [SW-1:0]          r_best;
    logic [31:0]            r_lead_prio;

    logic                   r_out_valid;
    t_pic_out               r_out_data;

    // address decode of the incoming beat
    logic [2:0]             n_kind;
    logic [SW-1:0]          n_sel;
    logic [CW-1:0]          n_ctx;
    logic [25:0]            en_rel;
    logic [25:0]            th_rel;
    logic [25:0]            off;

    always_comb begin
        off    = i_in_data.address;
        en_rel = off - OFF_ENABLE;
        th_rel = off - OFF_THRESHOLD;
        n_kind = K_NONE;
        n_sel  = off[2 +: SW];
        n_ctx  = '0;
        if (off < OFF_PENDING) begin
            if (32'(off[11:2]) < 32'(NUM_SOURCES)) begin
                n_kind = K_PRIO;
            end
        end else if (off == OFF_PENDING) begin
            n_kind = K_PEND;
        end else if (off >= OFF_ENABLE && off < OFF_THRESHOLD) begin
            n_ctx = en_rel[ENABLE_SHIFT +: CW];
            if (en_rel[ENABLE_SHIFT-1:0] == '0
                    && 32'(en_rel[25:ENABLE_SHIFT]) < 32'(NUM_CONTEXTS)) begin
                n_kind = K_ENAB;
            end
        end else if (off >= OFF_THRESHOLD) begin
            n_ctx = th_rel[CONTEXT_SHIFT +: CW];
            if (32'(th_rel[25:CONTEXT_SHIFT]) < 32'(NUM_CONTEXTS)) begin
                if (th_rel[CONTEXT_SHIFT-1:0] == '0) begin
                    n_kind = K_THRESH;
                end else if (th_rel[CONTEXT_SHIFT-1:0] == OFF_CLAIM) begin
                    n_kind = K_CLAIM;
                end
            end
        end
    end

    // priority memory port control
    logic          mem_we;
    logic          mem_re;
    logic [SW-1:0] mem_ra;
    logic [31:0]   prio_q;

    assign mem_we = (r_state == S_EXEC) && (r_cmd == CMD_WRITE) && (r_kind == K_PRIO);
    assign mem_re = ((r_state == S_EXEC) && (r_cmd == CMD_READ) && (r_kind == K_PRIO))
                  || ((r_state == S_SCAN) && r_issue);
    assign mem_ra = (r_state == S_SCAN) ? r_sidx : r_sel;
    assign prio_q = r_q_vld ? r_mem_q : 32'd0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_sel] <= r_wdata;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_ra];
        end
    end

    // scan compare on the word that just came out of the memory
    logic          ready_bit;
    logic          take;
    logic [SW-1:0] best_now;
    logic          scan_last;
    logic          in_acc;
    logic          out_free;

    assign ready_bit = r_pending[r_cidx] & r_enable[r_ctx][r_cidx] & ~r_claimed[r_cidx];
    assign take      = r_cvld && ready_bit && (prio_q > r_thresh[r_ctx])
                     && (prio_q > r_lead_prio);
    assign best_now  = take ? r_cidx : r_best;
    assign scan_last = r_cvld && (r_cidx == LAST_SRC);
    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pending   <= '0;
            r_claimed   <= '0;
            r_prio_vld  <= '0;
            r_q_vld     <= 1'b0;
            r_issue     <= 1'b0;
            r_cvld      <= 1'b0;
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
                r_enable[c] <= '0;
                r_thresh[c] <= '0;
            end
        end else begin
            if (mem_re) begin
                r_q_vld <= r_prio_vld[mem_ra];
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= i_in_data.command;
                        r_wdata <= i_in_data.write_data;
                        r_src   <= i_in_data.source;
                        r_kind  <= n_kind;
                        r_sel   <= n_sel;
                        r_ctx   <= n_ctx;
                        r_rd    <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // default: walk for the supervisor line
                    r_ctx        <= CW'(SUPERVISOR_CTX);
                    r_claim_scan <= 1'b0;
                    r_sidx       <= SW'(1);
                    r_issue      <= 1'b1;
                    r_cvld       <= 1'b0;
                    r_best       <= '0;
                    r_lead_prio  <= '0;
                    r_state      <= S_SCAN;
                    case (r_cmd)
                        CMD_READ: begin
                            unique case (r_kind)
                                K_PRIO: begin
                                    r_issue <= 1'b0;
                                    r_state <= S_PRD;
                                end
                                K_PEND:   r_rd <= 32'(r_pending);
                                K_ENAB:   r_rd <= r_enable[r_ctx];
                                K_THRESH: r_rd <= r_thresh[r_ctx];
                                K_CLAIM: begin
                                    // walk for the claiming context first
                                    r_ctx        <= r_ctx;
                                    r_claim_scan <= 1'b1;
                                end
                                default: r_rd <= '0;
                            endcase
                        end
                        CMD_WRITE: begin
                            unique case (r_kind)
                                K_PRIO:   r_prio_vld[r_sel] <= 1'b1;
                                K_ENAB:   r_enable[r_ctx]   <= r_wdata;
                                K_THRESH: r_thresh[r_ctx]   <= r_wdata;
                                K_CLAIM: begin
                                    if (r_wdata != '0 && r_wdata < 32'(NUM_SOURCES)) begin
                                        r_claimed[r_wdata[SW-1:0]] <= 1'b0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        CMD_RAISE: begin
                            if (r_src != '0 && 32'(r_src) < 32'(NUM_SOURCES)) begin
                                r_pending[r_src[SW-1:0]] <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_PRD: begin
                    r_rd    <= prio_q;
                    r_issue <= 1'b1;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_issue) begin
                        if (r_sidx == LAST_SRC) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_sidx <= r_sidx + SW'(1);
                        end
                    end
                    r_cidx <= r_sidx;
                    r_cvld <= r_issue;
                    if (take) begin
                        r_best      <= r_cidx;
                        r_lead_prio <= prio_q;
                    end
                    if (scan_last) begin
                        if (r_claim_scan) begin
                            r_rd <= 32'(best_now);
                            if (best_now != '0) begin
                                r_claimed[best_now] <= 1'b1;
                                r_pending[best_now] <= 1'b0;
                            end
                            r_ctx        <= CW'(SUPERVISOR_CTX);
                            r_claim_scan <= 1'b0;
                            r_sidx       <= SW'(1);
                            r_issue      <= 1'b1;
                            r_cvld       <= 1'b0;
                            r_best       <= '0;
                            r_lead_prio  <= '0;
                        end else begin
                            r_irq   <= (best_now != '0);
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid                <= 1'b1;
                        r_out_data.read_data      <= r_rd;
                        r_out_data.supervisor_irq <= r_irq;
                        r_state                   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### rtl/pic_checker.sv
// ----------------------------------------------------------------------------
// pic_port_checks
// Port-level checks of the interrupt controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pic_port_checks
    import pic_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_stall,
    input wire t_pic_in  i_in_data,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall,
    input wire t_pic_out o_out_data
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // reset leaves both sides empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not idle after reset");

    // an accepted beat sets the input side busy; the design keeps it so until its result lands
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken while a beat is in flight");

    // input side frees up only together with a new result beat
    a_free_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(o_in_stall) |-> o_out_valid && !$past(o_out_valid && i_out_stall)
            || $past(i_rst_n) && $fell(o_in_stall) && o_out_valid)
        else $error("input freed without a result");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind platform_interrupt_controller_unit pic_port_checks u_pic_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
